// File: rtl/lfsb_pkg.sv
package lfsb_pkg;

   // Transaction codes on the request channel. Code 3 has no meaning.
   typedef enum logic [1:0] {
      OP_ARM  = 2'd0,
      OP_SCAN = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   // Remembered steering direction.
   typedef enum logic [1:0] {
      TRACK_NONE     = 2'd0,
      TRACK_LEFT     = 2'd1,
      TRACK_STRAIGHT = 2'd2,
      TRACK_RIGHT    = 2'd3
   } track_type;

   // Last mark seen under the bar code reader.
   typedef enum logic [1:0] {
      MARK_WIDE   = 2'd0,
      MARK_NARROW = 2'd1,
      MARK_LIGHT  = 2'd2
   } mark_type;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_TH    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE_TH      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAR_DARK_TH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAR_LIGHT_TH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAR_NARROW   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT      = 3'd5;

   localparam int unsigned SAMPLE_W    = 10;
   localparam int unsigned TICK_W      = 16;
   localparam int unsigned DIGIT_CNT_W = 3;
   localparam int unsigned DIGIT_POS_W = 2;

   localparam logic [SAMPLE_W-1:0] CENTER_TH_RST    = 10'd175;
   localparam logic [SAMPLE_W-1:0] SIDE_TH_RST      = 10'd70;
   localparam logic [SAMPLE_W-1:0] BAR_DARK_TH_RST  = 10'd18;
   localparam logic [SAMPLE_W-1:0] BAR_LIGHT_TH_RST = 10'd70;
   localparam logic [SAMPLE_W-1:0] BAR_NARROW_RST   = 10'd60;
   localparam logic [TICK_W-1:0]   TIMEOUT_RST      = 16'd300;
   localparam logic [TICK_W-1:0]   TICK_MAX         = 16'hFFFF;

   typedef struct packed {
      logic                   motor_a_full;
      logic                   motor_b_full;
      logic                   drive_enable;
      logic                   digit_write;
      logic                   digit_value;
      logic [DIGIT_POS_W-1:0] digit_position;
      logic                   code_done;
      logic                   code_timeout;
   } result_type;

endpackage

// File: rtl/line_follow_steer_and_bar_reader.sv
// Results: an armed scan's result is registered into the output register, or into the skid
// register while that is full and not emptied; button, tick and unarmed scans give none.
// Throughput: one request transaction per cycle; a two-entry result buffer (output register
// plus skid register) decouples the channels, and req_stall rises only when both are full.
// Reset (synchronous, active high) restores default thresholds, disarms the block, empties
// the result buffer, stops the reader and leaves both motors on, drive high, no heading.
module line_follow_steer_and_bar_reader import lfsb_pkg::*; #(
   parameter int CODE_DIGITS = 4
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic [SAMPLE_W-1:0]    req_center_sample,
   input  logic [SAMPLE_W-1:0]    req_right_sample,
   input  logic [SAMPLE_W-1:0]    req_left_sample,
   input  logic [SAMPLE_W-1:0]    req_reader_sample,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_motor_a_full,
   output logic                   rsp_motor_b_full,
   output logic                   rsp_drive_enable,
   output logic                   rsp_digit_write,
   output logic                   rsp_digit_value,
   output logic [DIGIT_POS_W-1:0] rsp_digit_position,
   output logic                   rsp_code_done,
   output logic                   rsp_code_timeout,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]      csr_wdata
);

   // The digit counter is three bits wide and wraps, so the code length is compared
   // in that width.
   localparam logic [DIGIT_CNT_W-1:0] CodeDigits = DIGIT_CNT_W'(CODE_DIGITS);

   // Configuration registers.
   logic [SAMPLE_W-1:0] center_th_ff;
   logic [SAMPLE_W-1:0] side_th_ff;
   logic [SAMPLE_W-1:0] bar_dark_th_ff;
   logic [SAMPLE_W-1:0] bar_light_th_ff;
   logic [SAMPLE_W-1:0] bar_narrow_ff;
   logic [TICK_W-1:0]   timeout_ff;

   // Steering and reader state.
   logic                   armed_ff,         armed_in;
   track_type              last_track_ff,    last_track_in;
   logic                   motor_a_on_ff,    motor_a_on_in;
   logic                   motor_b_on_ff,    motor_b_on_in;
   logic                   drive_pin_ff,     drive_pin_in;
   logic                   reader_active_ff, reader_active_in;
   mark_type               last_mark_ff,     last_mark_in;
   logic [DIGIT_CNT_W-1:0] digits_read_ff,   digits_read_in;
   logic [TICK_W-1:0]      tick_count_ff,    tick_count_in;
   logic                   timer_running_ff, timer_running_in;

   // Result buffer: output register and skid register.
   result_type rsp_data_ff;
   logic       rsp_valid_ff;
   result_type skid_data_ff;
   logic       skid_valid_ff;

   logic       req_accept;
   logic       rsp_take;
   logic       has_result;
   result_type result;

   // The skid register is the only place a result can wait once the output register is
   // occupied, so the request side stalls exactly while it is full.
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign csr_ready  = 1'b1;

   // Configuration writes. Indexes beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         center_th_ff    <= CENTER_TH_RST;
         side_th_ff      <= SIDE_TH_RST;
         bar_dark_th_ff  <= BAR_DARK_TH_RST;
         bar_light_th_ff <= BAR_LIGHT_TH_RST;
         bar_narrow_ff   <= BAR_NARROW_RST;
         timeout_ff      <= TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CENTER_TH:    center_th_ff    <= csr_wdata[SAMPLE_W-1:0];
            CSR_SIDE_TH:      side_th_ff      <= csr_wdata[SAMPLE_W-1:0];
            CSR_BAR_DARK_TH:  bar_dark_th_ff  <= csr_wdata[SAMPLE_W-1:0];
            CSR_BAR_LIGHT_TH: bar_light_th_ff <= csr_wdata[SAMPLE_W-1:0];
            CSR_BAR_NARROW:   bar_narrow_ff   <= csr_wdata[SAMPLE_W-1:0];
            CSR_TIMEOUT:      timeout_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state and result for the transaction on the request ports. The reader rules
   // are applied in order, each seeing what the one before it left, because the light
   // and dark tests can both hold when the thresholds are set oddly.
   always_comb begin
      logic      center_hit;
      logic      dark;
      logic      light;
      logic      narrow;
      track_type dir;

      armed_in         = armed_ff;
      last_track_in    = last_track_ff;
      motor_a_on_in    = motor_a_on_ff;
      motor_b_on_in    = motor_b_on_ff;
      drive_pin_in     = drive_pin_ff;
      reader_active_in = reader_active_ff;
      last_mark_in     = last_mark_ff;
      digits_read_in   = digits_read_ff;
      tick_count_in    = tick_count_ff;
      timer_running_in = timer_running_ff;
      has_result       = 1'b0;
      result           = '0;

      center_hit = req_center_sample < center_th_ff;
      dark       = req_reader_sample < bar_dark_th_ff;
      light      = req_reader_sample > bar_light_th_ff;
      narrow     = (req_reader_sample < bar_narrow_ff) && (req_reader_sample > bar_dark_th_ff);

      // Steering: centre first, then right, then left, else the remembered direction.
      if (center_hit) begin
         dir = TRACK_STRAIGHT;
      end else if (req_right_sample < side_th_ff) begin
         dir = TRACK_RIGHT;
      end else if (req_left_sample < side_th_ff) begin
         dir = TRACK_LEFT;
      end else begin
         dir = last_track_ff;
      end

      case (op_type'(req_op))
         OP_ARM: begin
            armed_in = 1'b1;
         end
         OP_TICK: begin
            if (timer_running_ff && tick_count_ff != TICK_MAX) begin
               tick_count_in = tick_count_ff + 1'b1;
            end
         end
         OP_SCAN: begin
            if (armed_ff) begin
               has_result = 1'b1;

               // With nothing remembered the motors keep their duty and drive drops.
               // A remembered straight resumes as a right turn.
               if (dir == TRACK_NONE) begin
                  drive_pin_in = 1'b0;
               end else begin
                  last_track_in = dir;
                  drive_pin_in  = 1'b1;
                  if (dir == TRACK_LEFT) begin
                     motor_a_on_in = 1'b0;
                     motor_b_on_in = 1'b1;
                  end else if (center_hit) begin
                     motor_a_on_in = 1'b1;
                     motor_b_on_in = 1'b1;
                  end else begin
                     motor_a_on_in = 1'b1;
                     motor_b_on_in = 1'b0;
                  end
               end

               // A dark reading starts a code and its timer.
               if (!reader_active_in && dark) begin
                  reader_active_in = 1'b1;
                  last_mark_in     = MARK_WIDE;
                  timer_running_in = 1'b1;
               end

               // Light background ends a bar; after the last digit the code is complete.
               if (reader_active_in && light) begin
                  if (last_mark_in == MARK_WIDE || last_mark_in == MARK_NARROW) begin
                     last_mark_in = MARK_LIGHT;
                  end
                  if (digits_read_in == CodeDigits) begin
                     reader_active_in = 1'b0;
                     digits_read_in   = '0;
                     timer_running_in = 1'b0;
                     tick_count_in    = '0;
                     drive_pin_in     = 1'b0;
                     result.code_done = 1'b1;
                  end
               end

               // A dark reading is a wide bar. If a narrow bar was just written, the
               // reading was only the edge of a wide one: rewrite that position as zero.
               if (reader_active_in && dark) begin
                  if (last_mark_in == MARK_LIGHT) begin
                     result.digit_write    = 1'b1;
                     result.digit_value    = 1'b0;
                     result.digit_position = digits_read_in[DIGIT_POS_W-1:0];
                     digits_read_in        = digits_read_in + 1'b1;
                     last_mark_in          = MARK_WIDE;
                  end else if (last_mark_in == MARK_NARROW) begin
                     result.digit_write    = 1'b1;
                     result.digit_value    = 1'b0;
                     result.digit_position = DIGIT_POS_W'(digits_read_in - 1'b1);
                     last_mark_in          = MARK_WIDE;
                  end
               end

               // A mid reading after background is a narrow bar.
               if (reader_active_in && narrow && last_mark_in == MARK_LIGHT) begin
                  result.digit_write    = 1'b1;
                  result.digit_value    = 1'b1;
                  result.digit_position = digits_read_in[DIGIT_POS_W-1:0];
                  digits_read_in        = digits_read_in + 1'b1;
                  last_mark_in          = MARK_NARROW;
               end

               // Abandon an incomplete code once the tick count reaches the limit.
               if (reader_active_in && tick_count_in >= timeout_ff &&
                   digits_read_in < CodeDigits) begin
                  timer_running_in    = 1'b0;
                  tick_count_in       = '0;
                  reader_active_in    = 1'b0;
                  digits_read_in      = '0;
                  result.code_timeout = 1'b1;
               end

               result.motor_a_full = motor_a_on_in;
               result.motor_b_full = motor_b_on_in;
               result.drive_enable = drive_pin_in;
            end
         end
         default: ;
      endcase
   end

   // State commits only when the request transaction is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff         <= 1'b0;
         last_track_ff    <= TRACK_NONE;
         motor_a_on_ff    <= 1'b1;
         motor_b_on_ff    <= 1'b1;
         drive_pin_ff     <= 1'b1;
         reader_active_ff <= 1'b0;
         last_mark_ff     <= MARK_WIDE;
         digits_read_ff   <= '0;
         tick_count_ff    <= '0;
         timer_running_ff <= 1'b0;
      end else if (req_accept) begin
         armed_ff         <= armed_in;
         last_track_ff    <= last_track_in;
         motor_a_on_ff    <= motor_a_on_in;
         motor_b_on_ff    <= motor_b_on_in;
         drive_pin_ff     <= drive_pin_in;
         reader_active_ff <= reader_active_in;
         last_mark_ff     <= last_mark_in;
         digits_read_ff   <= digits_read_in;
         tick_count_ff    <= tick_count_in;
         timer_running_ff <= timer_running_in;
      end
   end

   // Result buffer valid bits. A new result goes to the output register when it is free
   // or being emptied this cycle, and to the skid register otherwise. While the skid
   // register is full no request is taken, and it drains into the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept && has_result) begin
         if (rsp_valid_ff && !rsp_take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result buffer payload.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (req_accept && has_result) begin
         if (rsp_valid_ff && !rsp_take) begin
            skid_data_ff <= result;
         end else begin
            rsp_data_ff <= result;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motor_a_full   = rsp_data_ff.motor_a_full;
   assign rsp_motor_b_full   = rsp_data_ff.motor_b_full;
   assign rsp_drive_enable   = rsp_data_ff.drive_enable;
   assign rsp_digit_write    = rsp_data_ff.digit_write;
   assign rsp_digit_value    = rsp_data_ff.digit_value;
   assign rsp_digit_position = rsp_data_ff.digit_position;
   assign rsp_code_done      = rsp_data_ff.code_done;
   assign rsp_code_timeout   = rsp_data_ff.code_timeout;

   // The skid register only fills behind a waiting output register.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // Every path that stops the code timer also clears the tick count.
   a_idle_timer_clear: assert property (@(posedge clock) disable iff (reset)
      !timer_running_ff |-> tick_count_ff == '0)
      else $error("tick count nonzero while timer stopped");

   // A code cannot be completed and abandoned in the same scan.
   a_done_or_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_code_done && rsp_code_timeout))
      else $error("code done and timeout in one result");

   // Digit fields stay zero when no digit is written.
   a_digit_fields_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_digit_write) |-> (!rsp_digit_value && rsp_digit_position == '0))
      else $error("digit fields set without a digit write");

endmodule

// File: dv/tb_top.sv
module tb_top;
   import lfsb_pkg::*;

   // The block is built with four code digits, and the checker below expects the same.
   localparam int DIGITS = 4;

   // The request op field has one code with no meaning. The block must ignore it.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // A register index that maps to nothing. A write to it must not disturb any threshold.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   // The run ends as a failure after this many cycles in a row in which no transaction
   // completes on any channel. Both sides stall only in random bursts far shorter than this.
   localparam int STUCK_LIMIT = 1000;

   // One request transaction as the sender sees it.
   typedef struct packed {
      logic [1:0]          op;
      logic [SAMPLE_W-1:0] center;
      logic [SAMPLE_W-1:0] right;
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] reader;
   } sensor_item_type;

   logic clock;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_op = OP_ARM;
   logic [SAMPLE_W-1:0]    req_center_sample = '0;
   logic [SAMPLE_W-1:0]    req_right_sample = '0;
   logic [SAMPLE_W-1:0]    req_left_sample = '0;
   logic [SAMPLE_W-1:0]    req_reader_sample = '0;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_motor_a_full;
   logic                   rsp_motor_b_full;
   logic                   rsp_drive_enable;
   logic                   rsp_digit_write;
   logic                   rsp_digit_value;
   logic [DIGIT_POS_W-1:0] rsp_digit_position;
   logic                   rsp_code_done;
   logic                   rsp_code_timeout;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_CENTER_TH;
   logic [TICK_W-1:0]      csr_wdata = '0;

   line_follow_steer_and_bar_reader #(
      .CODE_DIGITS(DIGITS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_center_sample  (req_center_sample),
      .req_right_sample   (req_right_sample),
      .req_left_sample    (req_left_sample),
      .req_reader_sample  (req_reader_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_motor_a_full   (rsp_motor_a_full),
      .rsp_motor_b_full   (rsp_motor_b_full),
      .rsp_drive_enable   (rsp_drive_enable),
      .rsp_digit_write    (rsp_digit_write),
      .rsp_digit_value    (rsp_digit_value),
      .rsp_digit_position (rsp_digit_position),
      .rsp_code_done      (rsp_code_done),
      .rsp_code_timeout   (rsp_code_timeout),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Shadow copy of the block. The thresholds follow every register write the block accepts,
   // and the steering and reader state follow every request transaction it accepts.
   // ---------------------------------------------------------------------------------------
   logic [SAMPLE_W-1:0]    th_center;
   logic [SAMPLE_W-1:0]    th_side;
   logic [SAMPLE_W-1:0]    th_dark;
   logic [SAMPLE_W-1:0]    th_light;
   logic [SAMPLE_W-1:0]    th_narrow;
   logic [TICK_W-1:0]      th_timeout;

   logic                   is_armed;
   track_type              last_track;
   logic                   motor_a_on;
   logic                   motor_b_on;
   logic                   drive_pin;
   logic                   reader_active;
   mark_type               last_mark;
   logic [DIGIT_CNT_W-1:0] digits_read;
   logic [TICK_W-1:0]      tick_count;
   logic                   timer_running;

   // Scan results the block still owes, oldest first.
   result_type      predicted_results[$];
   // Request transactions waiting for the driver.
   sensor_item_type sensor_items[$];

   int unsigned items_queued = 0;
   int unsigned items_accepted = 0;
   int unsigned csr_writes_done = 0;
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;

   // Set at each rising edge when the presented request was taken, read by the driver at
   // the following falling edge.
   logic        req_taken = 1'b0;
   // Idling is switched off for one stretch and for the final part of the run.
   logic        idling_on = 1'b1;
   int unsigned req_gap = 0;
   int unsigned stall_left = 0;

   task automatic clear_shadow();
      th_center     = CENTER_TH_RST;
      th_side       = SIDE_TH_RST;
      th_dark       = BAR_DARK_TH_RST;
      th_light      = BAR_LIGHT_TH_RST;
      th_narrow     = BAR_NARROW_RST;
      th_timeout    = TIMEOUT_RST;
      is_armed      = 1'b0;
      last_track    = TRACK_NONE;
      motor_a_on    = 1'b1;
      motor_b_on    = 1'b1;
      drive_pin     = 1'b1;
      reader_active = 1'b0;
      last_mark     = MARK_WIDE;
      digits_read   = '0;
      tick_count    = '0;
      timer_running = 1'b0;
   endtask

   task automatic apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [TICK_W-1:0] data);
      case (idx)
         CSR_CENTER_TH:    th_center  = data[SAMPLE_W-1:0];
         CSR_SIDE_TH:      th_side    = data[SAMPLE_W-1:0];
         CSR_BAR_DARK_TH:  th_dark    = data[SAMPLE_W-1:0];
         CSR_BAR_LIGHT_TH: th_light   = data[SAMPLE_W-1:0];
         CSR_BAR_NARROW:   th_narrow  = data[SAMPLE_W-1:0];
         CSR_TIMEOUT:      th_timeout = data;
         default: ;
      endcase
   endtask

   // Advances the shadow state by one accepted request and queues the scan result, if any.
   task automatic follow_and_decode(input sensor_item_type it);
      track_type  dir;
      result_type res;
      logic       center_hit;
      res = '0;
      if (it.op == OP_ARM) begin
         is_armed = 1'b1;
         return;
      end
      if (it.op == OP_TICK) begin
         if (timer_running && tick_count != TICK_MAX) tick_count = tick_count + 1'b1;
         return;
      end
      if (it.op != OP_SCAN || !is_armed) return;

      // Steering: centre wins over right, right over left, otherwise keep the old heading.
      center_hit = it.center < th_center;
      if (center_hit) dir = TRACK_STRAIGHT;
      else if (it.right < th_side) dir = TRACK_RIGHT;
      else if (it.left < th_side) dir = TRACK_LEFT;
      else dir = last_track;

      if (dir == TRACK_NONE) begin
         // Nothing seen and nothing remembered: stop, but leave the duties as they were.
         drive_pin = 1'b0;
      end else begin
         last_track = dir;
         drive_pin  = 1'b1;
         if (dir == TRACK_LEFT) begin
            motor_a_on = 1'b0;
            motor_b_on = 1'b1;
         end else if (center_hit) begin
            motor_a_on = 1'b1;
            motor_b_on = 1'b1;
         end else begin
            // A remembered straight heading comes back as a right turn.
            motor_a_on = 1'b1;
            motor_b_on = 1'b0;
         end
      end

      // Bar code reader. A dark bar while idle starts a code and the timer.
      if (!reader_active && it.reader < th_dark) begin
         reader_active = 1'b1;
         last_mark     = MARK_WIDE;
         timer_running = 1'b1;
      end
      if (reader_active && it.reader > th_light) begin
         last_mark = MARK_LIGHT;
         if (digits_read == DIGITS) begin
            reader_active    = 1'b0;
            digits_read      = '0;
            timer_running    = 1'b0;
            tick_count       = '0;
            drive_pin        = 1'b0;
            res.code_done    = 1'b1;
         end
      end
      if (reader_active && it.reader < th_dark) begin
         if (last_mark == MARK_LIGHT) begin
            res.digit_write    = 1'b1;
            res.digit_value    = 1'b0;
            res.digit_position = digits_read[DIGIT_POS_W-1:0];
            digits_read        = digits_read + 1'b1;
            last_mark          = MARK_WIDE;
         end else if (last_mark == MARK_NARROW) begin
            // The narrow bar was really the edge of a wide one: rewrite the previous digit.
            res.digit_write    = 1'b1;
            res.digit_value    = 1'b0;
            res.digit_position = digits_read[DIGIT_POS_W-1:0] - 1'b1;
            last_mark          = MARK_WIDE;
         end
      end
      if (reader_active && it.reader < th_narrow && it.reader > th_dark &&
          last_mark == MARK_LIGHT) begin
         res.digit_write    = 1'b1;
         res.digit_value    = 1'b1;
         res.digit_position = digits_read[DIGIT_POS_W-1:0];
         digits_read        = digits_read + 1'b1;
         last_mark          = MARK_NARROW;
      end
      if (reader_active && tick_count >= th_timeout && digits_read < DIGITS) begin
         timer_running    = 1'b0;
         tick_count       = '0;
         reader_active    = 1'b0;
         digits_read      = '0;
         res.code_timeout = 1'b1;
      end

      res.motor_a_full = motor_a_on;
      res.motor_b_full = motor_b_on;
      res.drive_enable = drive_pin;
      predicted_results.push_back(res);
   endtask

   task automatic compare_field(input string name, input int unsigned want_v,
                                input int unsigned got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         error_count++;
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Monitor. Everything is sampled at the rising edge, where the inputs driven at the
   // falling edge are settled and the block's outputs still hold their pre-edge values.
   // The result check runs before the prediction so that a result completing at the same
   // edge as a new request can never be matched against that request's expectation.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      logic       progress;
      req_taken = 1'b0;
      progress  = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            if (predicted_results.size() == 0) begin
               $error("scan result transaction with no result expected");
               error_count++;
            end else begin
               want = predicted_results.pop_front();
               compare_field("motor_a_full", want.motor_a_full, rsp_motor_a_full);
               compare_field("motor_b_full", want.motor_b_full, rsp_motor_b_full);
               compare_field("drive_enable", want.drive_enable, rsp_drive_enable);
               compare_field("digit_write", want.digit_write, rsp_digit_write);
               compare_field("digit_value", want.digit_value, rsp_digit_value);
               compare_field("digit_position", want.digit_position, rsp_digit_position);
               compare_field("code_done", want.code_done, rsp_code_done);
               compare_field("code_timeout", want.code_timeout, rsp_code_timeout);
            end
         end
         if (csr_valid && csr_ready) begin
            progress = 1'b1;
            apply_register(csr_index, csr_wdata);
            csr_writes_done++;
         end
         if (req_valid && !req_stall) begin
            progress  = 1'b1;
            req_taken = 1'b1;
            follow_and_decode('{req_op, req_center_sample, req_right_sample,
                                req_left_sample, req_reader_sample});
            items_accepted++;
         end
         if (progress) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STUCK_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Request driver. A presented transaction is held, payload unchanged, until it is taken.
   // Between transactions the sender may go quiet for a burst of cycles, and while quiet the
   // payload wanders so that the block is seen to ignore it.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      sensor_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // Still waiting for the block to take the current transaction.
      end else if (idling_on && req_gap > 0) begin
         req_gap--;
         req_valid <= 1'b0;
         req_op <= 2'($urandom_range(0, 3));
         req_reader_sample <= SAMPLE_W'($urandom);
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         req_gap = $urandom_range(1, 12) - 1;
         req_valid <= 1'b0;
         req_center_sample <= SAMPLE_W'($urandom);
      end else if (sensor_items.size() != 0) begin
         it = sensor_items.pop_front();
         req_op            <= it.op;
         req_center_sample <= it.center;
         req_right_sample  <= it.right;
         req_left_sample   <= it.left;
         req_reader_sample <= it.reader;
         req_valid         <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result side back-pressure in random bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (idling_on && stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------------------
   task automatic add_item(input logic [1:0] op, input int unsigned c, input int unsigned r,
                           input int unsigned l, input int unsigned rd);
      sensor_items.push_back('{op, SAMPLE_W'(c), SAMPLE_W'(r), SAMPLE_W'(l), SAMPLE_W'(rd)});
      items_queued++;
   endtask

   // Steering samples land below, on or above the threshold, or at the ends of the range.
   function automatic int unsigned pick_steer(input logic [SAMPLE_W-1:0] th);
      case ($urandom_range(0, 5))
         0, 1: return (th == 0) ? 0 : $urandom_range(0, th - 1);
         2: return th;
         3: return 1023;
         4: return 0;
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   function automatic int unsigned pick_dark();
      if (th_dark == 0) return $urandom_range(0, 1023);
      if ($urandom_range(0, 7) == 0) return th_dark - 1;
      return $urandom_range(0, th_dark - 1);
   endfunction

   function automatic int unsigned pick_light();
      if (th_light >= 1023) return 1023;
      return $urandom_range(th_light + 1, 1023);
   endfunction

   function automatic int unsigned pick_narrow();
      if (th_narrow > th_dark + 1) return $urandom_range(th_dark + 1, th_narrow - 1);
      return $urandom_range(0, 1023);
   endfunction

   // Readings sitting on a threshold, which must not count as the class beyond it.
   function automatic int unsigned pick_boundary();
      case ($urandom_range(0, 3))
         0: return th_dark;
         1: return th_narrow;
         2: return th_light;
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   task automatic add_scan(input int unsigned rd);
      add_item(OP_SCAN, pick_steer(th_center), pick_steer(th_side), pick_steer(th_side), rd);
   endtask

   task automatic add_ticks(input int unsigned n);
      repeat (n) add_item(OP_TICK, $urandom, $urandom, $urandom, $urandom);
   endtask

   // A plausible code under the reader: a start bar, then light gaps separating wide and
   // narrow bars, sometimes a narrow bar that turns out to be wide, some timer ticks, and a
   // closing light gap. The digit count varies around the code length so that short codes
   // run into the timeout and long ones finish early.
   task automatic add_code_run();
      int unsigned n;
      add_scan(pick_dark());
      n = $urandom_range(DIGITS - 1, DIGITS + 1);
      for (int unsigned i = 0; i < n; i++) begin
         add_scan(pick_light());
         if ($urandom_range(0, 3) == 0) add_scan(pick_boundary());
         if ($urandom_range(0, 1) == 1) begin
            add_scan(pick_narrow());
            if ($urandom_range(0, 3) == 0) add_scan(pick_dark());
         end else begin
            add_scan(pick_dark());
         end
         if ($urandom_range(0, 1) == 1) add_ticks($urandom_range(1, 4));
      end
      add_scan(pick_light());
   endtask

   // Mostly well-formed codes, with bursts of arbitrary transactions in between.
   task automatic add_random_part(input int unsigned n);
      int unsigned stop_at;
      stop_at = items_queued + n;
      while (items_queued < stop_at) begin
         if ($urandom_range(0, 3) != 0) begin
            add_code_run();
         end else begin
            repeat ($urandom_range(1, 5))
               add_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
         end
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [TICK_W-1:0] data);
      int unsigned target;
      target = csr_writes_done + 1;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      while (csr_writes_done != target) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input int unsigned c, input int unsigned s, input int unsigned d,
                             input int unsigned l, input int unsigned n,
                             input int unsigned t);
      write_register(CSR_CENTER_TH, TICK_W'(c));
      write_register(CSR_SIDE_TH, TICK_W'(s));
      write_register(CSR_BAR_DARK_TH, TICK_W'(d));
      write_register(CSR_BAR_LIGHT_TH, TICK_W'(l));
      write_register(CSR_BAR_NARROW, TICK_W'(n));
      write_register(CSR_TIMEOUT, TICK_W'(t));
   endtask

   // Waits until every queued transaction is taken and every result has come back, then
   // lets a few more cycles pass: ticks and ignored scans produce no result, so the block
   // may still be finishing one when the last result arrives.
   task automatic wait_for_quiet();
      while (items_accepted != items_queued || predicted_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------------------------
   initial begin
      int unsigned d;
      int unsigned n;
      clear_shadow();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset thresholds. Before the button nothing answers; then the
      // steering priority, the remembered heading (including straight coming back as a right
      // turn) and a full code with a narrow bar rewritten as wide, ending in done.
      add_item(OP_SCAN, 0, 0, 0, 0);
      add_item(OP_UNUSED, 1023, 1023, 1023, 1023);
      add_item(OP_TICK, 0, 0, 0, 0);
      add_item(OP_ARM, 1023, 0, 1023, 0);
      add_item(OP_SCAN, 1023, 1023, 1023, 1023);
      add_item(OP_SCAN, 174, 1023, 1023, 500);
      add_item(OP_SCAN, 175, 69, 0, 500);
      add_item(OP_SCAN, 175, 70, 69, 500);
      add_item(OP_SCAN, 1023, 1023, 1023, 500);
      add_item(OP_SCAN, 0, 0, 0, 500);
      add_item(OP_SCAN, 1023, 1023, 1023, 500);
      add_item(OP_SCAN, 100, 500, 500, 17);
      add_item(OP_SCAN, 100, 500, 500, 71);
      add_item(OP_SCAN, 300, 20, 500, 0);
      add_item(OP_SCAN, 300, 500, 20, 70);
      add_item(OP_SCAN, 300, 500, 500, 1023);
      add_item(OP_SCAN, 100, 500, 500, 59);
      add_item(OP_SCAN, 100, 500, 500, 18);
      add_item(OP_SCAN, 100, 500, 500, 5);
      add_item(OP_SCAN, 1023, 1023, 1023, 200);
      add_item(OP_SCAN, 1023, 1023, 1023, 19);
      add_item(OP_SCAN, 175, 0, 1023, 80);
      add_item(OP_SCAN, 175, 0, 1023, 10);
      add_item(OP_TICK, 1023, 1023, 1023, 1023);
      add_item(OP_SCAN, 175, 1023, 0, 71);
      wait_for_quiet();

      // A short timeout: three ticks after the start bar abandon the code.
      set_config(175, 70, 18, 70, 60, 3);
      add_item(OP_SCAN, 500, 500, 500, 5);
      add_ticks(3);
      add_item(OP_SCAN, 500, 500, 500, 500);
      add_item(OP_SCAN, 500, 500, 500, 5);
      add_item(OP_SCAN, 500, 500, 500, 500);
      wait_for_quiet();

      // A zero timeout gives up in the very scan that starts a code. A write to an unmapped
      // index must leave every threshold alone.
      write_register(CSR_TIMEOUT, 16'd0);
      write_register(CSR_UNMAPPED, 16'hFFFF);
      add_item(OP_SCAN, 500, 500, 500, 5);
      add_item(OP_SCAN, 500, 500, 500, 1023);
      wait_for_quiet();

      // Reset thresholds with a timeout that some codes reach and others beat.
      set_config(175, 70, 18, 70, 60, 12);
      add_random_part(350);
      wait_for_quiet();

      // All thresholds at zero: nothing is ever below them, so the heading is only what was
      // remembered and the reader never starts. No idling in this stretch.
      idling_on = 1'b0;
      set_config(0, 0, 0, 0, 0, 1);
      add_random_part(120);
      wait_for_quiet();

      // All thresholds at the top: nearly every reading is dark, nothing is ever light.
      idling_on = 1'b1;
      set_config(1023, 1023, 1023, 1023, 1023, 65535);
      add_random_part(150);
      wait_for_quiet();

      // Crossed thresholds: side above centre and dark above light, so one reading can be
      // light and dark at once.
      set_config(500, 600, 300, 100, 500, 6);
      add_random_part(300);
      wait_for_quiet();

      // Random but sensible thresholds, changed a few times.
      repeat (4) begin
         d = $urandom_range(1, 300);
         n = d + $urandom_range(2, 200);
         set_config($urandom_range(50, 600), $urandom_range(20, 400), d, n + $urandom_range(0, 200),
                    n, $urandom_range(3, 40));
         add_random_part(100);
         wait_for_quiet();
      end

      // A code left running well past its limit times out at the next scan, and the tick
      // count starts again from zero for the code after it.
      set_config(175, 70, 18, 70, 60, 20);
      add_scan(pick_dark());
      add_ticks(24);
      add_scan(500);
      add_scan(pick_dark());
      add_ticks(19);
      add_scan(500);
      wait_for_quiet();

      // Final stretch at full rate on both channels.
      idling_on = 1'b0;
      d = $urandom_range(1, 200);
      set_config($urandom_range(50, 600), $urandom_range(20, 400), d, d + 150, d + 60, 15);
      add_random_part(250);
      wait_for_quiet();

      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// File: line_follow_steer_and_bar_reader.f
rtl/lfsb_pkg.sv
rtl/line_follow_steer_and_bar_reader.sv
dv/tb_top.sv
